### hdl/obto_pkg.sv
// ----------------------------------------------------------------------------
// obto_pkg
// Shared widths, constants, sequencer codes and fixed-point helpers of the
// omni base twist odometry block.
// ----------------------------------------------------------------------------
package obto_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_MAX       = 30;

  localparam int VEL_W     = 16;
  localparam int POS_W     = 32;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // digit-serial multiplier operands
  localparam int A_W   = 40;
  localparam int B_W   = 36;
  localparam int DIG_W = 4;
  localparam int ACC_W = A_W + B_W;

  // CORDIC datapath
  localparam int ANG_W   = 34;
  localparam int Z_W     = 36;
  localparam int XY_W    = 34;
  localparam int ATAN_IW = 5;

  // wheel speed and small product registers
  localparam int WHL_W = 37;
  localparam int DXY_W = 22;
  localparam int TRG_W = 34;

  typedef logic signed [VEL_W-1:0] vel_t;
  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic signed [A_W-1:0]   opa_t;
  typedef logic signed [B_W-1:0]   opb_t;
  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAP_DIS = 3'd0,
    CFG_HOLO    = 3'd1,
    CFG_GAIN1   = 3'd2,
    CFG_GAIN2   = 3'd3,
    CFG_GAIN3   = 3'd4
  } cfg_idx_e;

  localparam vel_t LIM_V = 16'sd2048;
  localparam vel_t LIM_W = 16'sd4915;
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd16384;

  localparam opb_t K_ONE    = 36'sd65536;
  localparam opb_t K_LW     = 36'sd6554;
  localparam opb_t K_HALF   = 36'sd32768;
  localparam opb_t K_R3H    = 36'sd56756;
  localparam opb_t K_2_3    = 36'sd43691;
  localparam opb_t K_1_3    = 36'sd21845;
  localparam opb_t K_R3_3   = 36'sd37837;
  localparam opb_t K_INV3LW = 36'sd218453;

  localparam pos_t Q30_ONE_P = 32'sd1073741824;
  localparam acc_t Q30_ONE_A = 76'sd1073741824;
  localparam logic signed [XY_W-1:0] Q30_ONE_XY = 34'sd1073741824;
  localparam logic signed [XY_W-1:0] CORDIC_X0  = 34'sd652032874;
  localparam logic signed [Z_W-1:0]  PI_Z       = 36'sd3373259426;
  localparam logic signed [Z_W-1:0]  HALF_PI_Z  = 36'sd1686629713;

  // sequencer steps, one product each
  typedef enum logic [5:0] {
    OP_WZDT, OP_VXDT, OP_VYDT,
    OP_QWQW, OP_QZQZ, OP_QWQZ,
    OP_CYDX, OP_SYDY, OP_SYDX, OP_CYDY,
    OP_QWS,  OP_QZC,  OP_QWC,  OP_QZS,
    OP_V1X,  OP_V1W,
    OP_V2X,  OP_V2Y,  OP_V2W,
    OP_V3X,  OP_V3Y,  OP_V3W,
    OP_G1,   OP_G2,   OP_G3,
    OP_AX1,  OP_AX2,  OP_AX3,
    OP_AY3,  OP_AY2,
    OP_AW1,  OP_AW2,  OP_AW3
  } op_e;

  function automatic logic signed [31:0] atan_lut(input logic [ATAN_IW-1:0] i);
    logic signed [31:0] r;
    unique case (i)
      5'd0:  r = 32'sd843314857;
      5'd1:  r = 32'sd497837829;
      5'd2:  r = 32'sd263043837;
      5'd3:  r = 32'sd133525159;
      5'd4:  r = 32'sd67021687;
      5'd5:  r = 32'sd33543516;
      5'd6:  r = 32'sd16775851;
      5'd7:  r = 32'sd8388437;
      5'd8:  r = 32'sd4194283;
      5'd9:  r = 32'sd2097149;
      5'd10: r = 32'sd1048576;
      5'd11: r = 32'sd524288;
      5'd12: r = 32'sd262144;
      5'd13: r = 32'sd131072;
      5'd14: r = 32'sd65536;
      5'd15: r = 32'sd32768;
      5'd16: r = 32'sd16384;
      5'd17: r = 32'sd8192;
      5'd18: r = 32'sd4096;
      5'd19: r = 32'sd2048;
      5'd20: r = 32'sd1024;
      5'd21: r = 32'sd512;
      5'd22: r = 32'sd256;
      5'd23: r = 32'sd128;
      5'd24: r = 32'sd64;
      5'd25: r = 32'sd32;
      5'd26: r = 32'sd16;
      5'd27: r = 32'sd8;
      5'd28: r = 32'sd4;
      5'd29: r = 32'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round to nearest, ties away from zero
  function automatic acc_t rnd_sh(input acc_t v, input int unsigned s);
    acc_t half;
    acc_t neg;
    half = '0;
    half[s-1] = 1'b1;
    neg = $signed({{(ACC_W-1){1'b0}}, v[ACC_W-1]});
    return (v + half - neg) >>> s;
  endfunction

  function automatic pos_t sat32(input acc_t v);
    pos_t r;
    if (&v[ACC_W-1:POS_W-1] || ~|v[ACC_W-1:POS_W-1]) begin
      r = v[POS_W-1:0];
    end else begin
      r = v[ACC_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    return r;
  endfunction

  function automatic pos_t satq(input acc_t v);
    pos_t r;
    if (v > Q30_ONE_A) begin
      r = Q30_ONE_P;
    end else if (v < -Q30_ONE_A) begin
      r = -Q30_ONE_P;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic vel_t sat16(input acc_t v);
    vel_t r;
    if (&v[ACC_W-1:VEL_W-1] || ~|v[ACC_W-1:VEL_W-1]) begin
      r = v[VEL_W-1:0];
    end else begin
      r = v[ACC_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### hdl/obto_if.sv
// ----------------------------------------------------------------------------
// obto_in_if / obto_out_if
// Valid/ready channels of the command input and the odometry result.
// ----------------------------------------------------------------------------
interface obto_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] cmd_vx;
  logic signed [15:0] cmd_vy;
  logic signed [15:0] cmd_wz;
  logic        [15:0] step_time;

  modport source(output valid, cmd_vx, cmd_vy, cmd_wz, step_time, input ready);
  modport sink(input valid, cmd_vx, cmd_vy, cmd_wz, step_time, output ready);
endinterface

interface obto_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] capped_vx;
  logic signed [15:0] capped_vy;
  logic signed [15:0] capped_wz;
  logic signed [15:0] actual_vx;
  logic signed [15:0] actual_vy;
  logic signed [15:0] actual_wz;
  logic signed [31:0] odom_x;
  logic signed [31:0] odom_y;
  logic signed [31:0] odom_qz;
  logic signed [31:0] odom_qw;

  modport source(output valid, capped_vx, capped_vy, capped_wz, actual_vx, actual_vy,
                 actual_wz, odom_x, odom_y, odom_qz, odom_qw, input ready);
  modport sink(input valid, capped_vx, capped_vy, capped_wz, actual_vx, actual_vy,
               actual_wz, odom_x, odom_y, odom_qz, odom_qw, output ready);
endinterface

### hdl/obto_mul.sv
// ----------------------------------------------------------------------------
// obto_mul
// Digit-serial signed multiplier: the multiplier operand shifts out one
// 4-bit digit per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module obto_mul #(
  parameter int AW = obto_pkg::A_W,
  parameter int BW = obto_pkg::B_W,
  parameter int DW = obto_pkg::DIG_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic                    busy,
  output logic signed [AW+BW-1:0] p
);
  localparam int ND = BW / DW;
  localparam int CW = $clog2(ND + 1);

  logic signed [AW-1:0]    a_r;
  logic        [BW-1:0]    b_r;
  logic signed [AW+BW-1:0] p_r;
  logic        [CW-1:0]    cnt_r;
  logic                    busy_r;

  logic        [DW-1:0]    dig;
  logic signed [DW:0]      dig_s;
  logic signed [AW+DW:0]   part;

  always_comb begin
    dig = b_r[BW-1 -: DW];
    // top digit carries the sign
    dig_s = $signed({(cnt_r == CW'(ND)) ? dig[DW-1] : 1'b0, dig});
    part = a_r * dig_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(ND);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
      p_r <= '0;
    end else if (busy_r) begin
      p_r <= (p_r <<< DW) + (AW+BW)'(part);
      b_r <= b_r << DW;
    end
  end

  assign busy = busy_r;
  assign p    = p_r;

endmodule

### hdl/obto_cordic.sv
// ----------------------------------------------------------------------------
// obto_cordic
// Iterative rotation-mode CORDIC, one iteration per cycle, giving sin/cos
// of a Q3.30 angle with quadrant folding.
// ----------------------------------------------------------------------------
module obto_cordic #(
  parameter int STEPS = obto_pkg::CORDIC_STEPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  obto_pkg::ang_t             ang,
  output logic                       busy,
  output obto_pkg::pos_t             sin_o,
  output obto_pkg::pos_t             cos_o
);
  import obto_pkg::*;

  localparam int IW = $clog2(STEPS + 1);

  logic signed [XY_W-1:0] x_r, y_r, xs, ys, xf, yf;
  logic signed [Z_W-1:0]  z_r, z0, atan_z;
  logic                   flip_r, flip0;
  logic [IW-1:0]          i_r;
  logic                   busy_r;

  always_comb begin
    z0    = Z_W'(ang);
    flip0 = 1'b0;
    if (z0 > HALF_PI_Z) begin
      z0    = z0 - PI_Z;
      flip0 = 1'b1;
    end else if (z0 < -HALF_PI_Z) begin
      z0    = z0 + PI_Z;
      flip0 = 1'b1;
    end
    xs     = x_r >>> i_r;
    ys     = y_r >>> i_r;
    atan_z = Z_W'(atan_lut(ATAN_IW'(i_r)));
    xf     = flip_r ? -x_r : x_r;
    yf     = flip_r ? -y_r : y_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      i_r    <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      i_r    <= '0;
    end else if (busy_r) begin
      i_r <= i_r + IW'(1);
      if (i_r == IW'(STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= CORDIC_X0;
      y_r    <= '0;
      z_r    <= z0;
      flip_r <= flip0;
    end else if (busy_r) begin
      if (z_r >= 0) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_z;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_z;
      end
    end
  end

  always_comb begin
    if (yf > Q30_ONE_XY) sin_o = Q30_ONE_P;
    else if (yf < -Q30_ONE_XY) sin_o = -Q30_ONE_P;
    else sin_o = yf[POS_W-1:0];
    if (xf > Q30_ONE_XY) cos_o = Q30_ONE_P;
    else if (xf < -Q30_ONE_XY) cos_o = -Q30_ONE_P;
    else cos_o = xf[POS_W-1:0];
  end

  assign busy = busy_r;

endmodule

### hdl/omni_base_twist_odometry.sv
// ----------------------------------------------------------------------------
// omni_base_twist_odometry
// Three-wheel omni base: speed cap, pose odometry and wheel round trip.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one velocity command and time step per transfer; out_ch
//   returns one result per command: the capped command, the twist after the
//   gain-scaled wheel round trip and the updated pose and heading.
//   cfg_we/cfg_idx/cfg_wdata write the cap, holonomic and wheel gain
//   registers; write them only while no command is in flight.
// Operation:
//   A command runs 33 products through one digit-serial multiplier that
//   takes 4-bit digits of a 36-bit operand, plus issue, accumulate and
//   write-back steps. The CORDIC runs beside the multiplier.
//   One command is worked on at a time.
// Reset:
//   Pose clears to the origin, heading to the unit quaternion; caps on,
//   holonomic off, all gains 1.0.
// Stall:
//   A finished result waits in the output register; the next command is
//   taken meanwhile and holds in its last step until the register frees.
// ----------------------------------------------------------------------------
module omni_base_twist_odometry #(
  parameter int CORDIC_STEPS = obto_pkg::CORDIC_STEPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  obto_in_if.sink                          in_ch,
  obto_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [obto_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [obto_pkg::CFG_W-1:0]       cfg_wdata
);
  import obto_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_ISSUE = 6'b000010,
    S_WAIT  = 6'b000100,
    S_ACC   = 6'b001000,
    S_WB    = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  op_e    op_r;

  // configuration
  logic              cap_dis_r, holo_r;
  logic [GAIN_W-1:0] g1_r, g2_r, g3_r;

  // pose state
  pos_t px_r, py_r, qz_r, qw_r;

  // per-command working registers
  vel_t                    vx_r, vy_r, wz_r;
  logic [15:0]             dt_r;
  logic signed [DXY_W-1:0] dx_r, dy_r;
  logic signed [TRG_W-1:0] cy_r, sy_r;
  pos_t                    nqz_r, nqw_r;
  logic signed [WHL_W-1:0] w1_r, w2_r, w3_r;
  vel_t                    ax_r, ay_r, aw_r;
  acc_t                    acc_r;

  // output register
  logic out_valid_r;
  vel_t o_cvx_r, o_cvy_r, o_cwz_r, o_avx_r, o_avy_r, o_awz_r;
  pos_t o_x_r, o_y_r, o_qz_r, o_qw_r;

  // sequencer decode
  opa_t op_a;
  opb_t op_b;
  logic op_neg, op_first, op_last, op_trig;

  logic  mul_start, mul_busy;
  acc_t  mul_p;
  logic  cor_start, cor_busy;
  ang_t  cor_ang;
  pos_t  sin_v, cos_v;

  logic  in_fire, out_load;
  vel_t  cap_vx, cap_vy, cap_wz;
  acc_t  prod;

  obto_mul #(.AW(A_W), .BW(B_W), .DW(DIG_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .busy  (mul_busy),
    .p     (mul_p)
  );

  obto_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .ang   (cor_ang),
    .busy  (cor_busy),
    .sin_o (sin_v),
    .cos_o (cos_v)
  );

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == S_IDLE);

  // speed cap
  always_comb begin
    cap_vx = in_ch.cmd_vx;
    cap_vy = in_ch.cmd_vy;
    cap_wz = in_ch.cmd_wz;
    if (!cap_dis_r) begin
      if (in_ch.cmd_vx > LIM_V) cap_vx = LIM_V;
      else if (in_ch.cmd_vx < -LIM_V) cap_vx = -LIM_V;
      if (in_ch.cmd_wz > LIM_W) cap_wz = LIM_W;
      else if (in_ch.cmd_wz < -LIM_W) cap_wz = -LIM_W;
      if (!holo_r) cap_vy = '0;
      else if (in_ch.cmd_vy > LIM_V) cap_vy = LIM_V;
      else if (in_ch.cmd_vy < -LIM_V) cap_vy = -LIM_V;
    end
  end

  // operand selection per step
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    op_neg   = 1'b0;
    op_first = 1'b0;
    op_last  = 1'b0;
    op_trig  = 1'b0;
    unique case (op_r)
      OP_WZDT: begin op_a = A_W'(wz_r); op_b = B_W'($signed({1'b0, dt_r}));
                     op_first = 1'b1; op_last = 1'b1; end
      OP_VXDT: begin op_a = A_W'(vx_r); op_b = B_W'($signed({1'b0, dt_r}));
                     op_first = 1'b1; op_last = 1'b1; end
      OP_VYDT: begin op_a = A_W'(vy_r); op_b = B_W'($signed({1'b0, dt_r}));
                     op_first = 1'b1; op_last = 1'b1; end
      OP_QWQW: begin op_a = A_W'(qw_r); op_b = B_W'(qw_r); op_first = 1'b1; end
      OP_QZQZ: begin op_a = A_W'(qz_r); op_b = B_W'(qz_r); op_neg = 1'b1;
                     op_last = 1'b1; end
      OP_QWQZ: begin op_a = A_W'(qw_r); op_b = B_W'(qz_r);
                     op_first = 1'b1; op_last = 1'b1; end
      OP_CYDX: begin op_a = A_W'(cy_r); op_b = B_W'(dx_r); op_first = 1'b1; end
      OP_SYDY: begin op_a = A_W'(sy_r); op_b = B_W'(dy_r); op_neg = 1'b1;
                     op_last = 1'b1; end
      OP_SYDX: begin op_a = A_W'(sy_r); op_b = B_W'(dx_r); op_first = 1'b1; end
      OP_CYDY: begin op_a = A_W'(cy_r); op_b = B_W'(dy_r); op_last = 1'b1; end
      OP_QWS:  begin op_a = A_W'(qw_r); op_b = B_W'(sin_v); op_first = 1'b1;
                     op_trig = 1'b1; end
      OP_QZC:  begin op_a = A_W'(qz_r); op_b = B_W'(cos_v); op_last = 1'b1;
                     op_trig = 1'b1; end
      OP_QWC:  begin op_a = A_W'(qw_r); op_b = B_W'(cos_v); op_first = 1'b1;
                     op_trig = 1'b1; end
      OP_QZS:  begin op_a = A_W'(qz_r); op_b = B_W'(sin_v); op_neg = 1'b1;
                     op_last = 1'b1; op_trig = 1'b1; end
      OP_V1X:  begin op_a = A_W'(vx_r); op_b = K_ONE; op_first = 1'b1; end
      OP_V1W:  begin op_a = A_W'(wz_r); op_b = K_LW; op_neg = 1'b1; op_last = 1'b1; end
      OP_V2X:  begin op_a = A_W'(vx_r); op_b = K_HALF; op_neg = 1'b1;
                     op_first = 1'b1; end
      OP_V2Y:  begin op_a = A_W'(vy_r); op_b = K_R3H; op_neg = 1'b1; end
      OP_V2W:  begin op_a = A_W'(wz_r); op_b = K_LW; op_neg = 1'b1; op_last = 1'b1; end
      OP_V3X:  begin op_a = A_W'(vx_r); op_b = K_HALF; op_neg = 1'b1;
                     op_first = 1'b1; end
      OP_V3Y:  begin op_a = A_W'(vy_r); op_b = K_R3H; end
      OP_V3W:  begin op_a = A_W'(wz_r); op_b = K_LW; op_neg = 1'b1; op_last = 1'b1; end
      OP_G1:   begin op_a = A_W'(w1_r); op_b = B_W'($signed({1'b0, g1_r}));
                     op_first = 1'b1; op_last = 1'b1; end
      OP_G2:   begin op_a = A_W'(w2_r); op_b = B_W'($signed({1'b0, g2_r}));
                     op_first = 1'b1; op_last = 1'b1; end
      OP_G3:   begin op_a = A_W'(w3_r); op_b = B_W'($signed({1'b0, g3_r}));
                     op_first = 1'b1; op_last = 1'b1; end
      OP_AX1:  begin op_a = A_W'(w1_r); op_b = K_2_3; op_first = 1'b1; end
      OP_AX2:  begin op_a = A_W'(w2_r); op_b = K_1_3; op_neg = 1'b1; end
      OP_AX3:  begin op_a = A_W'(w3_r); op_b = K_1_3; op_neg = 1'b1; op_last = 1'b1; end
      OP_AY3:  begin op_a = A_W'(w3_r); op_b = K_R3_3; op_first = 1'b1; end
      OP_AY2:  begin op_a = A_W'(w2_r); op_b = K_R3_3; op_neg = 1'b1; op_last = 1'b1; end
      OP_AW1:  begin op_a = A_W'(w1_r); op_b = K_INV3LW; op_neg = 1'b1;
                     op_first = 1'b1; end
      OP_AW2:  begin op_a = A_W'(w2_r); op_b = K_INV3LW; op_neg = 1'b1; end
      OP_AW3:  begin op_a = A_W'(w3_r); op_b = K_INV3LW; op_neg = 1'b1;
                     op_last = 1'b1; end
      default: ;
    endcase
  end

  assign mul_start = (state_r == S_ISSUE) && !(op_trig && cor_busy);
  assign cor_start = (state_r == S_WB) && (op_r == OP_WZDT);
  // half angle doubled to Q30
  assign cor_ang   = $signed({acc_r[ANG_W-2:0], 1'b0});
  assign prod      = op_neg ? -mul_p : mul_p;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_ISSUE;
      S_ISSUE: if (mul_start) state_nxt = S_WAIT;
      S_WAIT:  if (!mul_busy) state_nxt = S_ACC;
      S_ACC:   state_nxt = op_last ? S_WB : S_ISSUE;
      S_WB:    state_nxt = (op_r == OP_AW3) ? S_OUT : S_ISSUE;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_WZDT;
      out_valid_r <= 1'b0;
      cap_dis_r   <= 1'b0;
      holo_r      <= 1'b0;
      g1_r        <= GAIN_RST;
      g2_r        <= GAIN_RST;
      g3_r        <= GAIN_RST;
      px_r        <= '0;
      py_r        <= '0;
      qz_r        <= '0;
      qw_r        <= Q30_ONE_P;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        op_r <= OP_WZDT;
      end else if (state_r == S_WB || (state_r == S_ACC && !op_last)) begin
        if (op_r != OP_AW3) op_r <= op_e'(op_r + 6'd1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        if (cfg_idx == CFG_CAP_DIS) cap_dis_r <= cfg_wdata[0];
        if (cfg_idx == CFG_HOLO)    holo_r    <= cfg_wdata[0];
        if (cfg_idx == CFG_GAIN1)   g1_r      <= cfg_wdata;
        if (cfg_idx == CFG_GAIN2)   g2_r      <= cfg_wdata;
        if (cfg_idx == CFG_GAIN3)   g3_r      <= cfg_wdata;
      end
      if (state_r == S_WB) begin
        if (op_r == OP_SYDY) px_r <= sat32(acc_t'(px_r) + rnd_sh(acc_r, 30));
        if (op_r == OP_CYDY) py_r <= sat32(acc_t'(py_r) + rnd_sh(acc_r, 30));
      end
      // heading commits only once both new components are known
      if (out_load) begin
        qz_r <= nqz_r;
        qw_r <= nqw_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vx_r <= cap_vx;
      vy_r <= cap_vy;
      wz_r <= cap_wz;
      dt_r <= in_ch.step_time;
    end
    if (state_r == S_ACC) begin
      acc_r <= (op_first ? acc_t'(0) : acc_r) + prod;
    end
    if (state_r == S_WB) begin
      unique case (op_r)
        OP_VXDT: dx_r  <= DXY_W'(rnd_sh(acc_r, 12));
        OP_VYDT: dy_r  <= DXY_W'(rnd_sh(acc_r, 12));
        OP_QZQZ: cy_r  <= TRG_W'(rnd_sh(acc_r, 30));
        OP_QWQZ: sy_r  <= TRG_W'(rnd_sh(acc_r, 29));
        OP_QZC:  nqz_r <= satq(rnd_sh(acc_r, 30));
        OP_QZS:  nqw_r <= satq(rnd_sh(acc_r, 30));
        OP_V1W:  w1_r  <= WHL_W'(acc_r);
        OP_V2W:  w2_r  <= WHL_W'(acc_r);
        OP_V3W:  w3_r  <= WHL_W'(acc_r);
        OP_G1:   w1_r  <= WHL_W'(rnd_sh(acc_r, 14));
        OP_G2:   w2_r  <= WHL_W'(rnd_sh(acc_r, 14));
        OP_G3:   w3_r  <= WHL_W'(rnd_sh(acc_r, 14));
        OP_AX3:  ax_r  <= sat16(rnd_sh(acc_r, 32));
        OP_AY2:  ay_r  <= sat16(rnd_sh(acc_r, 32));
        OP_AW3:  aw_r  <= sat16(rnd_sh(acc_r, 32));
        default: ;
      endcase
    end
    if (out_load) begin
      o_cvx_r <= vx_r;
      o_cvy_r <= vy_r;
      o_cwz_r <= wz_r;
      o_avx_r <= ax_r;
      o_avy_r <= ay_r;
      o_awz_r <= aw_r;
      o_x_r   <= px_r;
      o_y_r   <= py_r;
      o_qz_r  <= nqz_r;
      o_qw_r  <= nqw_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.capped_vx = o_cvx_r;
  assign out_ch.capped_vy = o_cvy_r;
  assign out_ch.capped_wz = o_cwz_r;
  assign out_ch.actual_vx = o_avx_r;
  assign out_ch.actual_vy = o_avy_r;
  assign out_ch.actual_wz = o_awz_r;
  assign out_ch.odom_x    = o_x_r;
  assign out_ch.odom_y    = o_y_r;
  assign out_ch.odom_qz   = o_qz_r;
  assign out_ch.odom_qw   = o_qw_r;

endmodule
